[rtl/whpa_pkg.sv]
// Shared constants and types for the weighted HPWL accumulator.
// No dependencies; used by whpa_front, whpa_back and weighted_hpwl_accumulator.
`default_nettype none

package whpa_pkg;

   localparam int COORD_WIDTH_DEF      = 32;
   localparam int WEIGHT_FRAC_BITS_DEF = 8;

   localparam int PIN_WIDTH    = 32;
   localparam int WEIGHT_WIDTH = 16;
   localparam int LEN_WIDTH    = 41;
   localparam int TOTAL_WIDTH  = 63;
   localparam int QUEUE_DEPTH  = 4;

   // Per-net attributes, captured at the net's closing pin.
   typedef struct packed {
      logic                    design_end;
      logic                    net_enabled;
      logic [WEIGHT_WIDTH-1:0] net_weight;
   } net_flags_type;

   localparam int NET_FLAGS_WIDTH = $bits(net_flags_type);

endpackage

`default_nettype wire

[rtl/whpa_front.sv]
// Front end: tracks the net's bounding box, one pin per cycle while pin_take is high.
// Pushes the final box and net flags into the queue on the closing pin. Uses whpa_pkg.
`default_nettype none

module whpa_front #(
   parameter int COORD_WIDTH = whpa_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               pin_take,
   input  wire logic [whpa_pkg::PIN_WIDTH-1:0]     pin_x,
   input  wire logic [whpa_pkg::PIN_WIDTH-1:0]     pin_y,
   input  wire logic                               net_end,
   input  wire whpa_pkg::net_flags_type            pin_flags,
   output logic                                    push,
   output logic [4*COORD_WIDTH-1:0]                push_box,
   output whpa_pkg::net_flags_type                 push_flags
);

   localparam int XW = COORD_WIDTH + whpa_pkg::PIN_WIDTH;

   logic [XW-1:0]          x_ext, y_ext;
   logic [COORD_WIDTH-1:0] x_c, y_c, bx, by;
   logic [COORD_WIDTH-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [COORD_WIDTH-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic                   first_ff;
   logic                   closing;

   // Coordinates as COORD_WIDTH two's complement, then offset binary so
   // unsigned compares give signed order.
   assign x_ext = {{COORD_WIDTH{pin_x[whpa_pkg::PIN_WIDTH-1]}}, pin_x};
   assign y_ext = {{COORD_WIDTH{pin_y[whpa_pkg::PIN_WIDTH-1]}}, pin_y};
   assign x_c   = x_ext[COORD_WIDTH-1:0];
   assign y_c   = y_ext[COORD_WIDTH-1:0];
   assign bx    = {~x_c[COORD_WIDTH-1], x_c[COORD_WIDTH-2:0]};
   assign by    = {~y_c[COORD_WIDTH-1], y_c[COORD_WIDTH-2:0]};

   always_comb begin
      if (first_ff) begin
         min_x_in = bx;
         max_x_in = bx;
         min_y_in = by;
         max_y_in = by;
      end else begin
         min_x_in = (bx < min_x_ff) ? bx : min_x_ff;
         max_x_in = (bx > max_x_ff) ? bx : max_x_ff;
         min_y_in = (by < min_y_ff) ? by : min_y_ff;
         max_y_in = (by > max_y_ff) ? by : max_y_ff;
      end
   end

   // design_end alone also closes the net
   assign closing    = net_end | pin_flags.design_end;
   assign push       = pin_take & closing;
   assign push_box   = {max_y_in, min_y_in, max_x_in, min_x_in};
   assign push_flags = pin_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (pin_take) begin
         first_ff <= closing;
      end
   end

   always_ff @(posedge clock) begin
      if (pin_take) begin
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
   end

endmodule

`default_nettype wire

[rtl/whpa_queue.sv]
// Small FIFO between the box tracker and the length pipeline.
// Storage is a register array; depends on nothing else.
`default_nettype none

module whpa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_data  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/whpa_back.sv]
// Back end: span, weight multiply, shift and saturate, running total.
// Four register stages, all held while the result register waits. Uses whpa_pkg.
`default_nettype none

module whpa_back #(
   parameter int COORD_WIDTH      = whpa_pkg::COORD_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = whpa_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                weights_enabled,
   input  wire logic                                q_valid,
   input  wire logic [4*COORD_WIDTH-1:0]            q_box,
   input  wire whpa_pkg::net_flags_type             q_flags,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [whpa_pkg::LEN_WIDTH-1:0]           rsp_net_length,
   output logic [whpa_pkg::TOTAL_WIDTH-1:0]         rsp_total_length,
   output logic                                     rsp_design_done
);

   localparam int LW = whpa_pkg::LEN_WIDTH;
   localparam int TW = whpa_pkg::TOTAL_WIDTH;
   localparam int WW = whpa_pkg::WEIGHT_WIDTH;
   localparam int SW = COORD_WIDTH + 1;
   localparam int PW = SW + WW;
   localparam int EW = (PW > 65) ? PW : 65;

   logic                   adv;
   logic [COORD_WIDTH-1:0] dx, dy;
   logic [SW-1:0]          span;

   logic                   v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic [SW-1:0]          span1_ff;
   whpa_pkg::net_flags_type flags1_ff;
   logic [WW-1:0]          wsel;
   logic [PW-1:0]          prod2_ff;
   logic                   done2_ff, done3_ff;
   logic [EW-1:0]          prod_ext, shifted;
   logic                   sat_len;
   logic [LW-1:0]          len3_ff, len_in;
   logic [TW:0]            sum;
   logic [TW-1:0]          total_in, total_ff;
   logic [LW-1:0]          out_len_ff;
   logic [TW-1:0]          out_total_ff;
   logic                   out_done_ff;

   assign adv   = ~out_valid_ff | rsp_ready;
   assign q_pop = adv & q_valid;

   // box layout: {max_y, min_y, max_x, min_x}
   assign dx   = q_box[2*COORD_WIDTH-1:COORD_WIDTH] - q_box[COORD_WIDTH-1:0];
   assign dy   = q_box[4*COORD_WIDTH-1:3*COORD_WIDTH] - q_box[3*COORD_WIDTH-1:2*COORD_WIDTH];
   assign span = {1'b0, dx} + {1'b0, dy};

   // masked net multiplies by zero; unweighted uses weight one
   always_comb begin
      if (!flags1_ff.net_enabled) begin
         wsel = '0;
      end else if (weights_enabled) begin
         wsel = flags1_ff.net_weight;
      end else begin
         wsel = WW'(1) << WEIGHT_FRAC_BITS;
      end
   end

   // product at or above 2^64, or shifted length at or above 2^LW, saturates
   assign prod_ext = EW'(prod2_ff);
   assign shifted  = prod_ext >> WEIGHT_FRAC_BITS;
   assign sat_len  = (|(prod_ext >> 64)) | (|(shifted >> LW));
   assign len_in   = sat_len ? {LW{1'b1}} : shifted[LW-1:0];

   assign sum      = {1'b0, total_ff} + (TW + 1)'(len3_ff);
   assign total_in = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else if (adv) begin
         v1_ff        <= q_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
         if (v3_ff) begin
            total_ff <= done3_ff ? '0 : total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         span1_ff     <= span;
         flags1_ff    <= q_flags;
         prod2_ff     <= PW'(span1_ff) * PW'(wsel);
         done2_ff     <= flags1_ff.design_end;
         len3_ff      <= len_in;
         done3_ff     <= done2_ff;
         out_len_ff   <= len3_ff;
         out_total_ff <= total_in;
         out_done_ff  <= done3_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_net_length   = out_len_ff;
   assign rsp_total_length = out_total_ff;
   assign rsp_design_done  = out_done_ff;

endmodule

`default_nettype wire

[rtl/weighted_hpwl_accumulator.sv]
// Weighted HPWL accumulator. Throughput: one pin per cycle while req_tready is
// high, set by the min/max box recurrence in the front end. A closing pin's net
// passes the queue, then the v1, v2, v3 and output registers, to rsp_tvalid; a
// 4-entry net queue lets the front keep taking pins while the result side stalls.
// Reset clears the box tracker, queue, pipeline valids, running total and
// the weights_enabled register. Uses whpa_pkg, whpa_front, whpa_queue, whpa_back.
`default_nettype none

module weighted_hpwl_accumulator #(
   parameter int COORD_WIDTH      = whpa_pkg::COORD_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = whpa_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [79:0]   req_tdata,   // pin_x[31:0], pin_y[63:32], net_weight[79:64]
   input  wire logic [1:0]    req_tuser,   // net_end[0], net_enabled[1]
   input  wire logic          req_tlast,   // design_end
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [103:0]       rsp_tdata,   // net_length[40:0], total_length[103:41]
   output logic               rsp_tlast,   // design_done
   input  wire logic          csr_wr_en,
   input  wire logic          csr_wr_data  // weights_enabled
);

   localparam int QW = 4 * COORD_WIDTH + whpa_pkg::NET_FLAGS_WIDTH;

   logic                                weights_en_ff;
   logic                                pin_take;
   whpa_pkg::net_flags_type             pin_flags, push_flags, q_flags;
   logic                                push, q_full, q_valid, q_pop;
   logic [4*COORD_WIDTH-1:0]            push_box, q_box;
   logic [QW-1:0]                       q_data;
   logic [whpa_pkg::LEN_WIDTH-1:0]      net_length;
   logic [whpa_pkg::TOTAL_WIDTH-1:0]    total_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         weights_en_ff <= csr_wr_data;
      end
   end

   // a pin that does not close a net never needs a queue slot, but taking
   // ready from full alone keeps ready independent of the payload
   assign req_tready = ~q_full;
   assign pin_take   = req_tvalid & req_tready;

   assign pin_flags.design_end  = req_tlast;
   assign pin_flags.net_enabled = req_tuser[1];
   assign pin_flags.net_weight  = req_tdata[79:64];

   whpa_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .pin_take   (pin_take),
      .pin_x      (req_tdata[31:0]),
      .pin_y      (req_tdata[63:32]),
      .net_end    (req_tuser[0]),
      .pin_flags  (pin_flags),
      .push       (push),
      .push_box   (push_box),
      .push_flags (push_flags)
   );

   whpa_queue #(
      .WIDTH (QW),
      .DEPTH (whpa_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_flags, push_box}),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   assign q_box   = q_data[4*COORD_WIDTH-1:0];
   assign q_flags = q_data[QW-1:4*COORD_WIDTH];

   whpa_back #(
      .COORD_WIDTH      (COORD_WIDTH),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .weights_enabled  (weights_en_ff),
      .q_valid          (q_valid),
      .q_box            (q_box),
      .q_flags          (q_flags),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_net_length   (net_length),
      .rsp_total_length (total_length),
      .rsp_design_done  (rsp_tlast)
   );

   assign rsp_tdata = {total_length, net_length};

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for weighted_hpwl_accumulator: streams pins net by net,
// predicts each net's weighted half-perimeter and running total, checks every result.
// Depends on rtl/whpa_pkg.sv and the weighted_hpwl_accumulator RTL.

module tb_top;

   localparam int NUM_DIRECTED = 21;
   localparam int PHASE_ITEMS  = 200;
   localparam int NUM_PHASES   = 6;

   localparam logic [63:0] LEN_SAT   = (64'd1 << whpa_pkg::LEN_WIDTH) - 64'd1;
   localparam logic [63:0] TOTAL_SAT = (64'd1 << whpa_pkg::TOTAL_WIDTH) - 64'd1;

   typedef struct packed {
      logic [whpa_pkg::PIN_WIDTH-1:0]    x;
      logic [whpa_pkg::PIN_WIDTH-1:0]    y;
      logic                              net_end;
      logic                              enabled;
      logic [whpa_pkg::WEIGHT_WIDTH-1:0] weight;
      logic                              design_end;
   } pin_item_type;

   typedef struct packed {
      logic [whpa_pkg::LEN_WIDTH-1:0]   len;
      logic [whpa_pkg::TOTAL_WIDTH-1:0] total;
      logic                             done;
   } net_result_type;

   typedef struct packed {
      logic           wcfg;
      pin_item_type   pin;
      logic           typed;
      net_result_type want;
   } pin_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [79:0] req_tdata;
   logic [1:0] req_tuser;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_wr_en;
   logic csr_wr_data;

   logic calm = 1'b0;
   int fail_count = 0;

   // predictor state; box held in offset binary so unsigned compare works
   logic [whpa_pkg::PIN_WIDTH-1:0]   box_lo_x, box_hi_x, box_lo_y, box_hi_y;
   logic                             first_pin = 1'b1;
   logic [whpa_pkg::TOTAL_WIDTH-1:0] total_acc = '0;
   logic                             weights_on = 1'b0;

   net_result_type expected_nets[$];

   logic [whpa_pkg::PIN_WIDTH-1:0] coord_corners [4] =
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

   pin_row_type directed [NUM_DIRECTED] = '{
      // weights off
      '{1'b0, '{32'd0, 32'd0, 1'b1, 1'b1, 16'd0, 1'b0}, 1'b1,
        '{41'd0, 63'd0, 1'b0}},
      '{1'b0, '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b0, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'd0, 1'b0}, 1'b1,
        '{41'h1_FFFF_FFFE, 63'h1_FFFF_FFFE, 1'b0}},
      // masked net
      '{1'b0, '{32'd100, 32'd5, 1'b0, 1'b1, 16'd256, 1'b0}, 1'b0, '0},
      '{1'b0, '{-32'd100, -32'd5, 1'b1, 1'b0, 16'd256, 1'b0}, 1'b1,
        '{41'd0, 63'h1_FFFF_FFFE, 1'b0}},
      // design end without net end
      '{1'b0, '{32'd10, 32'd20, 1'b0, 1'b1, 16'd256, 1'b1}, 1'b1,
        '{41'd0, 63'h1_FFFF_FFFE, 1'b1}},
      // new design after the total clears
      '{1'b0, '{32'd3, 32'd4, 1'b0, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b0, '{-32'd5, 32'd1, 1'b0, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b0, '{32'd7, -32'd2, 1'b1, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b0, '{32'd0, 32'd0, 1'b0, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b0, '{32'd1, 32'd1, 1'b1, 1'b1, 16'd0, 1'b1}, 1'b0, '0},
      // weights on
      '{1'b1, '{32'd0, 32'd0, 1'b0, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b1, '{32'd256, 32'd0, 1'b1, 1'b1, 16'd256, 1'b0}, 1'b0, '0},
      '{1'b1, '{32'd0, 32'd0, 1'b0, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b1, '{32'd1000, 32'd1000, 1'b1, 1'b1, 16'd0, 1'b0}, 1'b1,
        '{41'd0, 63'd256, 1'b0}},
      '{1'b1, '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b1, '{32'd5, 32'd5, 1'b0, 1'b1, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b1, '{32'd9, 32'd9, 1'b1, 1'b0, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{1'b1, '{-32'd1, -32'd1, 1'b0, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
      '{1'b1, '{32'd1, 32'd1, 1'b1, 1'b1, 16'h0180, 1'b1}, 1'b0, '0}
   };

   weighted_hpwl_accumulator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("weighted_hpwl_accumulator regression: fail");
      $finish;
   end

   // Advances the box by one pin; returns 1 with the net's result when it closes.
   function automatic logic hpwl_step(input pin_item_type p, output net_result_type r);
      logic [whpa_pkg::PIN_WIDTH-1:0] bx, by;
      logic [63:0] span, len;
      bx = p.x ^ 32'h8000_0000;
      by = p.y ^ 32'h8000_0000;
      r = '0;
      if (first_pin) begin
         box_lo_x = bx;
         box_hi_x = bx;
         box_lo_y = by;
         box_hi_y = by;
      end else begin
         if (bx < box_lo_x) box_lo_x = bx;
         if (bx > box_hi_x) box_hi_x = bx;
         if (by < box_lo_y) box_lo_y = by;
         if (by > box_hi_y) box_hi_y = by;
      end
      first_pin = 1'b0;
      if (!p.net_end && !p.design_end)
         return 1'b0;

      span = ({32'd0, box_hi_x} - {32'd0, box_lo_x}) + ({32'd0, box_hi_y} - {32'd0, box_lo_y});
      if (!p.enabled)
         len = '0;
      else if (weights_on) begin
         if (p.weight != 0 && span > 64'hFFFF_FFFF_FFFF_FFFF / p.weight)
            len = LEN_SAT;
         else
            len = (span * p.weight) >> whpa_pkg::WEIGHT_FRAC_BITS_DEF;
      end else
         len = span;
      if (len > LEN_SAT)
         len = LEN_SAT;

      if ({1'b0, total_acc} > TOTAL_SAT - len)
         total_acc = TOTAL_SAT[whpa_pkg::TOTAL_WIDTH-1:0];
      else
         total_acc = total_acc + len[whpa_pkg::TOTAL_WIDTH-1:0];

      r.len   = len[whpa_pkg::LEN_WIDTH-1:0];
      r.total = total_acc;
      r.done  = p.design_end;

      first_pin = 1'b1;
      if (p.design_end)
         total_acc = '0;
      return 1'b1;
   endfunction

   // Leaves req_tvalid high after the transfer; the caller's next step decides it.
   task automatic push_pin(input pin_item_type p, input logic use_given = 1'b0,
                           input net_result_type given = '0);
      net_result_type r;
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.weight, p.y, p.x};
      req_tuser  <= {p.enabled, p.net_end};
      req_tlast  <= p.design_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (hpwl_step(p, r))
         expected_nets.push_back(use_given ? given : r);
   endtask

   task automatic write_weights(input logic v);
      req_tvalid <= 1'b0;
      while (expected_nets.size() != 0) @(posedge clock);
      // a pin that closes no net may still be in the pipeline
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      weights_on = v;
   endtask

   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(0, 99) >= 24);

   always @(posedge clock) begin : check_results
      net_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_nets.size() == 0) begin
            $error("result transfer with no net pending: net_length %0d", rsp_tdata[40:0]);
            fail_count++;
         end else begin
            want = expected_nets.pop_front();
            if (want.len !== rsp_tdata[40:0]) begin
               $error("net_length: expected %0d, got %0d", want.len, rsp_tdata[40:0]);
               fail_count++;
            end
            if (want.total !== rsp_tdata[103:41]) begin
               $error("total_length: expected %0d, got %0d", want.total, rsp_tdata[103:41]);
               fail_count++;
            end
            if (want.done !== rsp_tlast) begin
               $error("design_done: expected %0d, got %0d", want.done, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      pin_item_type p;
      logic [whpa_pkg::PIN_WIDTH-1:0] cx, cy;
      int nets, pins, mode, phase_items, wait_cycles;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_weights(1'b0);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed[i].wcfg != weights_on)
            write_weights(directed[i].wcfg);
         push_pin(directed[i].pin, directed[i].typed, directed[i].want);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_weights(ph % 2 == 0);
         calm <= (ph == 3);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            nets = $urandom_range(1, 8);
            for (int n = 0; n < nets; n++) begin
               // stray item with random framing bits
               if ($urandom_range(0, 9) == 0) begin
                  p = pin_item_type'({$urandom, $urandom, $urandom});
                  p.design_end = ($urandom_range(0, 7) == 0);
                  push_pin(p);
                  phase_items++;
                  continue;
               end
               case ($urandom_range(0, 19))
                  0:       pins = $urandom_range(13, 40);
                  1,2,3,4: pins = $urandom_range(5, 12);
                  default: pins = $urandom_range(1, 4);
               endcase
               mode = $urandom_range(0, 2);
               cx = $urandom;
               cy = $urandom;
               for (int k = 0; k < pins; k++) begin
                  case (mode)
                     0: begin
                        p.x = $urandom;
                        p.y = $urandom;
                     end
                     1: begin
                        p.x = cx + $urandom_range(0, 2047) - 1024;
                        p.y = cy + $urandom_range(0, 2047) - 1024;
                     end
                     default: begin
                        p.x = coord_corners[$urandom_range(0, 3)];
                        p.y = coord_corners[$urandom_range(0, 3)];
                     end
                  endcase
                  p.enabled = ($urandom_range(0, 9) != 0);
                  case ($urandom_range(0, 3))
                     0, 1:    p.weight = 16'd256;
                     2:       p.weight = 16'($urandom);
                     default: p.weight = 16'($urandom_range(0, 1023));
                  endcase
                  p.net_end    = (k == pins - 1);
                  p.design_end = 1'b0;
                  if (k == pins - 1 && n == nets - 1) begin
                     p.design_end = 1'b1;
                     if ($urandom_range(0, 3) == 0) p.net_end = 1'b0;
                  end
                  push_pin(p);
                  phase_items++;
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      calm <= 1'b0;
      wait_cycles = 0;
      while (wait_cycles < 2000 && expected_nets.size() != 0) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (expected_nets.size() != 0) begin
         $error("%0d net results never arrived", expected_nets.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("weighted_hpwl_accumulator regression: pass");
      else
         $display("weighted_hpwl_accumulator regression: fail");
      $finish;
   end

endmodule
